// ----- hw/rtl/maze_depth_first_explorer_top_assert.svh -----
// Assertion macros for the maze explorer; empty bodies under synthesis.
`ifndef MAZE_DEPTH_FIRST_EXPLORER_TOP_ASSERT_SVH
`define MAZE_DEPTH_FIRST_EXPLORER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define MDFE_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("mdfe assertion failed");

// Next-cycle implication
`define MDFE_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("mdfe assertion failed");

`else

`define MDFE_ASSERT_NOW(label, clk, rst_n, cond, prop)
`define MDFE_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// ----- hw/rtl/mdfe_pkg.sv -----
// Shared constants, codes and control types of the maze explorer.
package mdfe_pkg;

    localparam int GRID_SIDE   = 16;
    localparam int STORE_SIDE  = 2 * GRID_SIDE + 1;
    localparam int STORE_CELLS = STORE_SIDE * STORE_SIDE;
    localparam int MAZE_CELLS  = GRID_SIDE * GRID_SIDE;

    localparam int POS_W       = 4;
    localparam int MPOS_W      = $clog2(STORE_SIDE);
    localparam int MAZE_ADDR_W = $clog2(MAZE_CELLS);
    localparam int MARK_ADDR_W = $clog2(STORE_CELLS);
    localparam int MARK_W      = 9;
    localparam int KIND_W      = 2;
    localparam int OP_W        = 2;
    localparam int OUTCOME_W   = 3;
    localparam int PROBE_W     = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;

    // Operations
    localparam logic [OP_W-1:0] OP_LOAD    = OP_W'(0);
    localparam logic [OP_W-1:0] OP_RESTART = OP_W'(1);
    localparam logic [OP_W-1:0] OP_STEP    = OP_W'(2);

    // Cell kinds
    localparam logic [KIND_W-1:0] KIND_EMPTY = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_WALL  = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_EXIT  = KIND_W'(2);

    // Outcomes
    localparam logic [OUTCOME_W-1:0] OUT_ACCEPTED = OUTCOME_W'(0);
    localparam logic [OUTCOME_W-1:0] OUT_ADVANCED = OUTCOME_W'(1);
    localparam logic [OUTCOME_W-1:0] OUT_BACKED   = OUTCOME_W'(2);
    localparam logic [OUTCOME_W-1:0] OUT_STUCK    = OUTCOME_W'(3);
    localparam logic [OUTCOME_W-1:0] OUT_AT_EXIT  = OUTCOME_W'(4);

    // Probe order: the robot's own cell, then up, down, left, right
    localparam logic [PROBE_W-1:0] PROBE_HERE  = PROBE_W'(0);
    localparam logic [PROBE_W-1:0] PROBE_UP    = PROBE_W'(1);
    localparam logic [PROBE_W-1:0] PROBE_DOWN  = PROBE_W'(2);
    localparam logic [PROBE_W-1:0] PROBE_LEFT  = PROBE_W'(3);
    localparam logic [PROBE_W-1:0] PROBE_RIGHT = PROBE_W'(4);

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_START_ROW = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_START_COL = CFG_INDEX_W'(1);

    localparam logic [MARK_W-1:0]  MARK_MAX    = '1;
    localparam logic [MPOS_W-1:0]  MARK_CENTRE = MPOS_W'(GRID_SIDE);
    localparam logic [POS_W-1:0]   POS_LAST    = POS_W'(GRID_SIDE - 1);

    // Commands from controller to datapath
    typedef struct packed {
        logic                 load_wr;
        logic                 clear_start;
        logic                 clear_wr;
        logic                 restart_set;
        logic                 probe_rd;
        logic                 probe_ev;
        logic                 advance;
        logic                 backup;
        logic                 set_outcome;
        logic [OUTCOME_W-1:0] outcome;
        logic                 res_load;
        logic [PROBE_W-1:0]   probe_idx;
    } mdfe_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_last;
        logic exit_here;
        logic can_adv;
        logic back_any;
    } mdfe_stat_t;

endpackage

// ----- hw/rtl/mdfe_if.sv -----
// Valid/ready channel interfaces for input words and result words.
interface mdfe_item_if;
    import mdfe_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [POS_W-1:0]  cell_row;
    logic [POS_W-1:0]  cell_col;
    logic [KIND_W-1:0] cell_kind;

    modport source (output valid, operation, cell_row, cell_col, cell_kind, input ready);
    modport sink (input valid, operation, cell_row, cell_col, cell_kind, output ready);
endinterface

interface mdfe_result_if;
    import mdfe_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [POS_W-1:0]     robot_row;
    logic [POS_W-1:0]     robot_col;
    logic [OUTCOME_W-1:0] outcome;
    logic [MARK_W-1:0]    depth;

    modport source (output valid, robot_row, robot_col, outcome, depth, input ready);
    modport sink (input valid, robot_row, robot_col, outcome, depth, output ready);
endinterface

// ----- hw/rtl/maze_depth_first_explorer_top.sv -----
// Top level of the depth-first maze explorer: controller, datapath and channel wiring.
//
//  channel      dir   words                                    handshake
//  item_in      in    operation, cell_row, cell_col, cell_kind valid/ready
//  result_out   out   robot_row, robot_col, outcome, depth     valid/ready
//  cfg          in    cfg_index, cfg_wdata                     cfg_we, no wait
//
// One word is worked on at a time; a new word is taken once the previous result
// has moved into the output register. A step reads the maze and the visit mark of each
// probed cell (own cell, then up to four neighbours), with a read state and an evaluate
// state per probe. Restart clears the 1089-entry visit store one entry a cycle.
// After reset the same clear runs before the first word is taken; configuration writes
// are taken at any time. A stalled result holds its word.
`include "maze_depth_first_explorer_top_assert.svh"

module maze_depth_first_explorer_top (
    input  logic                             clk,
    input  logic                             rst_n,
    mdfe_item_if.sink                        item_in,
    mdfe_result_if.source                    result_out,
    input  logic                             cfg_we,
    input  logic [mdfe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mdfe_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import mdfe_pkg::*;

    mdfe_cmd_t  cmd;
    mdfe_stat_t stat;

    // Sequence the work
    mdfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_in.valid),
        .in_ready  (item_in.ready),
        .op        (item_in.operation),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold maze, marks and position
    mdfe_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cell_row  (item_in.cell_row),
        .cell_col  (item_in.cell_col),
        .cell_kind (item_in.cell_kind),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .robot_row (result_out.robot_row),
        .robot_col (result_out.robot_col),
        .outcome   (result_out.outcome),
        .depth     (result_out.depth)
    );

    `MDFE_ASSERT_NOW(a_move_excl, clk, rst_n, cmd.advance, !cmd.backup && !cmd.restart_set)
    `MDFE_ASSERT_NOW(a_clear_blocks_input, clk, rst_n, cmd.clear_wr, !item_in.ready)
    `MDFE_ASSERT_NOW(a_result_slot_free, clk, rst_n, cmd.res_load, !result_out.valid || result_out.ready)
    `MDFE_ASSERT_NEXT(a_result_shown, clk, rst_n, cmd.res_load, result_out.valid)

endmodule

// ----- hw/rtl/mdfe_datapath.sv -----
// Datapath: maze and visit-mark memories, robot and marker position, result register.
module mdfe_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mdfe_pkg::mdfe_cmd_t              cmd,
    output mdfe_pkg::mdfe_stat_t             stat,
    input  logic [mdfe_pkg::POS_W-1:0]       cell_row,
    input  logic [mdfe_pkg::POS_W-1:0]       cell_col,
    input  logic [mdfe_pkg::KIND_W-1:0]      cell_kind,
    input  logic                             cfg_we,
    input  logic [mdfe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mdfe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output logic [mdfe_pkg::POS_W-1:0]       robot_row,
    output logic [mdfe_pkg::POS_W-1:0]       robot_col,
    output logic [mdfe_pkg::OUTCOME_W-1:0]   outcome,
    output logic [mdfe_pkg::MARK_W-1:0]      depth
);
    import mdfe_pkg::*;

    function automatic logic [MAZE_ADDR_W-1:0] maze_addr(
        input logic [POS_W-1:0] r,
        input logic [POS_W-1:0] c
    );
        return MAZE_ADDR_W'(r) * MAZE_ADDR_W'(GRID_SIDE) + MAZE_ADDR_W'(c);
    endfunction

    function automatic logic [MARK_ADDR_W-1:0] mark_addr(
        input logic [MPOS_W-1:0] r,
        input logic [MPOS_W-1:0] c
    );
        return MARK_ADDR_W'(r) * MARK_ADDR_W'(STORE_SIDE) + MARK_ADDR_W'(c);
    endfunction

    function automatic logic [POS_W-1:0] clamp_start(input logic [POS_W-1:0] v);
        return (v > POS_LAST) ? POS_LAST : v;
    endfunction

    // Memories
    logic [KIND_W-1:0] maze_mem [MAZE_CELLS];
    logic [MARK_W-1:0] mark_mem [STORE_CELLS];

    // Configuration
    logic [POS_W-1:0] start_row_reg, start_col_reg;

    // Walk state
    logic [POS_W-1:0]       robot_row_reg, robot_col_reg;
    logic [MPOS_W-1:0]      mrow_reg, mcol_reg;
    logic [MARK_W-1:0]      here_reg;
    logic [MARK_ADDR_W-1:0] clr_addr_reg;

    // Probe payload
    logic [KIND_W-1:0]  maze_rd_reg;
    logic [MARK_W-1:0]  mark_rd_reg;
    logic [POS_W-1:0]   nb_row_reg, nb_col_reg;
    logic [MPOS_W-1:0]  nb_mrow_reg, nb_mcol_reg;
    logic               nb_in_grid_reg;

    // First back-up candidate seen
    logic               back_found_reg;
    logic [POS_W-1:0]   back_row_reg, back_col_reg;
    logic [MPOS_W-1:0]  back_mrow_reg, back_mcol_reg;

    // Result register
    logic [OUTCOME_W-1:0] outcome_reg;
    logic [POS_W-1:0]     res_row_reg, res_col_reg;
    logic [OUTCOME_W-1:0] res_outcome_reg;
    logic [MARK_W-1:0]    res_depth_reg;

    logic [POS_W-1:0]  nr, nc;
    logic [MPOS_W-1:0] nmr, nmc;
    logic              ning;
    logic              load_in_grid;
    logic              cur_back;
    logic [MARK_W-1:0] new_mark;

    // Pick the probed cell
    always_comb
    begin
        nr   = robot_row_reg;
        nc   = robot_col_reg;
        nmr  = mrow_reg;
        nmc  = mcol_reg;
        ning = 1'b1;
        unique case (cmd.probe_idx)
            PROBE_UP:
            begin
                nr   = robot_row_reg - POS_W'(1);
                nmr  = mrow_reg - MPOS_W'(1);
                ning = (robot_row_reg != '0);
            end
            PROBE_DOWN:
            begin
                nr   = robot_row_reg + POS_W'(1);
                nmr  = mrow_reg + MPOS_W'(1);
                ning = (robot_row_reg != POS_LAST);
            end
            PROBE_LEFT:
            begin
                nc   = robot_col_reg - POS_W'(1);
                nmc  = mcol_reg - MPOS_W'(1);
                ning = (robot_col_reg != '0);
            end
            PROBE_RIGHT:
            begin
                nc   = robot_col_reg + POS_W'(1);
                nmc  = mcol_reg + MPOS_W'(1);
                ning = (robot_col_reg != POS_LAST);
            end
            default:
            begin
                ning = 1'b1;
            end
        endcase
    end

    assign load_in_grid = ({1'b0, cell_row} < (POS_W+1)'(GRID_SIDE)) &&
                          ({1'b0, cell_col} < (POS_W+1)'(GRID_SIDE));

    assign new_mark = (here_reg == MARK_MAX) ? MARK_MAX : here_reg + MARK_W'(1);

    assign cur_back = nb_in_grid_reg && (here_reg > MARK_W'(1)) &&
                      (mark_rd_reg == here_reg - MARK_W'(1)) &&
                      (cmd.probe_idx != PROBE_HERE);

    // Status toward the controller
    always_comb
    begin
        stat.clear_last = (clr_addr_reg == MARK_ADDR_W'(STORE_CELLS - 1));
        stat.exit_here  = (maze_rd_reg == KIND_EXIT);
        stat.can_adv    = nb_in_grid_reg && (mark_rd_reg == '0) &&
                          ((maze_rd_reg == KIND_EMPTY) || (maze_rd_reg == KIND_EXIT));
        stat.back_any   = back_found_reg || cur_back;
    end

    // Maze memory: write on load, read on probe
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && load_in_grid)
        begin
            maze_mem[maze_addr(cell_row, cell_col)] <= cell_kind;
        end
        if (cmd.probe_rd)
        begin
            maze_rd_reg <= maze_mem[maze_addr(nr, nc)];
        end
    end

    // Visit-mark memory: one write and one read port
    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            mark_mem[clr_addr_reg] <= '0;
        end
        else if (cmd.restart_set)
        begin
            mark_mem[mark_addr(MARK_CENTRE, MARK_CENTRE)] <= MARK_W'(1);
        end
        else if (cmd.advance)
        begin
            mark_mem[mark_addr(nb_mrow_reg, nb_mcol_reg)] <= new_mark;
        end
        if (cmd.probe_rd)
        begin
            mark_rd_reg <= mark_mem[mark_addr(nmr, nmc)];
        end
    end

    // Latch probed coordinates, first back-up candidate, outcome and result word
    always_ff @(posedge clk)
    begin
        if (cmd.probe_rd)
        begin
            nb_row_reg     <= nr;
            nb_col_reg     <= nc;
            nb_mrow_reg    <= nmr;
            nb_mcol_reg    <= nmc;
            nb_in_grid_reg <= ning;
        end
        if (cmd.probe_ev && cur_back && !back_found_reg)
        begin
            back_row_reg  <= nb_row_reg;
            back_col_reg  <= nb_col_reg;
            back_mrow_reg <= nb_mrow_reg;
            back_mcol_reg <= nb_mcol_reg;
        end
        if (cmd.set_outcome)
        begin
            outcome_reg <= cmd.outcome;
        end
        if (cmd.res_load)
        begin
            res_row_reg     <= robot_row_reg;
            res_col_reg     <= robot_col_reg;
            res_outcome_reg <= cmd.set_outcome ? cmd.outcome : outcome_reg;
            res_depth_reg   <= here_reg;
        end
    end

    // Hold configuration, position, mark under the marker, clear counter and back-up flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_row_reg  <= POS_W'(1);
            start_col_reg  <= POS_W'(1);
            robot_row_reg  <= POS_W'(1);
            robot_col_reg  <= POS_W'(1);
            mrow_reg       <= MARK_CENTRE;
            mcol_reg       <= MARK_CENTRE;
            here_reg       <= '0;
            clr_addr_reg   <= '0;
            back_found_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_START_ROW))
            begin
                start_row_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == CFG_START_COL))
            begin
                start_col_reg <= cfg_wdata;
            end

            if (cmd.clear_start)
            begin
                clr_addr_reg <= '0;
            end
            else if (cmd.clear_wr)
            begin
                clr_addr_reg <= clr_addr_reg + MARK_ADDR_W'(1);
            end

            if (cmd.probe_ev)
            begin
                if (cmd.probe_idx == PROBE_HERE)
                begin
                    back_found_reg <= 1'b0;
                end
                else if (cur_back)
                begin
                    back_found_reg <= 1'b1;
                end
            end

            if (cmd.restart_set)
            begin
                robot_row_reg <= clamp_start(start_row_reg);
                robot_col_reg <= clamp_start(start_col_reg);
                mrow_reg      <= MARK_CENTRE;
                mcol_reg      <= MARK_CENTRE;
                here_reg      <= MARK_W'(1);
            end
            else if (cmd.advance)
            begin
                robot_row_reg <= nb_row_reg;
                robot_col_reg <= nb_col_reg;
                mrow_reg      <= nb_mrow_reg;
                mcol_reg      <= nb_mcol_reg;
                here_reg      <= new_mark;
            end
            else if (cmd.backup)
            begin
                robot_row_reg <= back_found_reg ? back_row_reg : nb_row_reg;
                robot_col_reg <= back_found_reg ? back_col_reg : nb_col_reg;
                mrow_reg      <= back_found_reg ? back_mrow_reg : nb_mrow_reg;
                mcol_reg      <= back_found_reg ? back_mcol_reg : nb_mcol_reg;
                here_reg      <= here_reg - MARK_W'(1);
            end
        end
    end

    assign robot_row = res_row_reg;
    assign robot_col = res_col_reg;
    assign outcome   = res_outcome_reg;
    assign depth     = res_depth_reg;

endmodule

// ----- hw/rtl/mdfe_ctrl.sv -----
// Controller: sequences load, clear, restart and the four-way probe of a step.
module mdfe_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mdfe_pkg::OP_W-1:0]   op,
    output logic                        out_valid,
    input  logic                        out_ready,
    input  mdfe_pkg::mdfe_stat_t        stat,
    output mdfe_pkg::mdfe_cmd_t         cmd
);
    import mdfe_pkg::*;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_CENTRE   = 3'd2;
    localparam logic [2:0] S_PROBE_RD = 3'd3;
    localparam logic [2:0] S_PROBE_EV = 3'd4;
    localparam logic [2:0] S_RESP     = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic               restart_reg, restart_next;
    logic [PROBE_W-1:0] probe_reg, probe_next;
    logic               out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        restart_next = restart_reg;
        probe_next   = probe_reg;
        cmd          = '0;
        cmd.probe_idx = probe_reg;
        in_ready     = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last)
                begin
                    state_next   = restart_reg ? S_CENTRE : S_IDLE;
                    restart_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (op)
                        OP_LOAD:
                        begin
                            cmd.load_wr     = 1'b1;
                            cmd.set_outcome = 1'b1;
                            cmd.outcome     = OUT_ACCEPTED;
                            state_next      = S_RESP;
                        end
                        OP_RESTART:
                        begin
                            cmd.clear_start = 1'b1;
                            restart_next    = 1'b1;
                            state_next      = S_CLEAR;
                        end
                        OP_STEP:
                        begin
                            probe_next = PROBE_HERE;
                            state_next = S_PROBE_RD;
                        end
                        default:
                        begin
                            cmd.set_outcome = 1'b1;
                            cmd.outcome     = OUT_ACCEPTED;
                            state_next      = S_RESP;
                        end
                    endcase
                end
            end
            S_CENTRE:
            begin
                cmd.restart_set = 1'b1;
                cmd.set_outcome = 1'b1;
                cmd.outcome     = OUT_ACCEPTED;
                state_next      = S_RESP;
            end
            S_PROBE_RD:
            begin
                cmd.probe_rd = 1'b1;
                state_next   = S_PROBE_EV;
            end
            S_PROBE_EV:
            begin
                cmd.probe_ev = 1'b1;
                if (probe_reg == PROBE_HERE)
                begin
                    if (stat.exit_here)
                    begin
                        cmd.set_outcome = 1'b1;
                        cmd.outcome     = OUT_AT_EXIT;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        probe_next = PROBE_UP;
                        state_next = S_PROBE_RD;
                    end
                end
                else if (stat.can_adv)
                begin
                    cmd.advance     = 1'b1;
                    cmd.set_outcome = 1'b1;
                    cmd.outcome     = OUT_ADVANCED;
                    state_next      = S_RESP;
                end
                else if (probe_reg == PROBE_RIGHT)
                begin
                    cmd.set_outcome = 1'b1;
                    if (stat.back_any)
                    begin
                        cmd.backup  = 1'b1;
                        cmd.outcome = OUT_BACKED;
                    end
                    else
                    begin
                        cmd.outcome = OUT_STUCK;
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    probe_next = probe_reg + PROBE_W'(1);
                    state_next = S_PROBE_RD;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result word until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            restart_reg   <= 1'b0;
            probe_reg     <= PROBE_HERE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            restart_reg   <= restart_next;
            probe_reg     <= probe_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
